/* hw/rtl/ilbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed latch bank mapper package
// Shared types, constants and variant codes for the bank mapper blocks.
// ----------------------------------------------------------------------------
package ilbm_pkg;

   // Address decode for the index register.
   localparam logic [15:0] SEL_MASK  = 16'h4101;
   localparam logic [15:0] SEL_MATCH = 16'h4100;

   localparam int NUM_LATCHES = 8;
   localparam int LATCH_BITS  = 3;

   // Latches referenced by the bank formulas.
   localparam int PRG_LATCH  = 5;
   localparam int HIGH_LATCH = 4;
   localparam int EXT_LATCH  = 6;
   localparam int MODE_LATCH = 7;

   // Board variants; only the low bits of each latch are ever used.
   typedef enum logic [1:0] {
      VARIANT_2K_PAIR  = 2'd0,
      VARIANT_2K_PLAIN = 2'd1,
      VARIANT_2K_QUAD  = 2'd2,
      VARIANT_1K_SPLIT = 2'd3
   } variant_type;

   typedef logic [NUM_LATCHES-1:0][LATCH_BITS-1:0] latch_array_type;

   // Request payload.
   typedef struct packed {
      logic [7:0]  data;
      logic [15:0] address;
   } req_type;

   // Response payload, last field in the lowest bits.
   typedef struct packed {
      logic [1:0] mirroring;
      logic       chr_slot_layout;
      logic [7:0] chr_bank_3;
      logic [7:0] chr_bank_2;
      logic [7:0] chr_bank_1;
      logic [7:0] chr_bank_0;
      logic [2:0] prg_bank;
   } rsp_type;

   localparam int REQ_BITS = $bits(req_type);
   localparam int RSP_BITS = $bits(rsp_type);
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;

endpackage

/* hw/rtl/ilbm_latch_file.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latch file
// Holds the index register and the eight bank latches, decodes each request
// and presents the latch contents as they stand after that request.
// ----------------------------------------------------------------------------
module ilbm_latch_file
   import ilbm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  req_type         wr_req,
   output latch_array_type latches_next
);

   logic [LATCH_BITS-1:0] index_ff;
   logic [LATCH_BITS-1:0] index_in;
   latch_array_type       latches_ff;
   latch_array_type       latches_in;
   logic                  index_hit;

   // An address matching the select pattern loads the index; any other
   // address writes the selected latch.
   always_comb begin
      index_hit  = (wr_req.address & SEL_MASK) == SEL_MATCH;
      index_in   = index_ff;
      latches_in = latches_ff;
      if (wr_en) begin
         if (index_hit) begin
            index_in = wr_req.data[LATCH_BITS-1:0];
         end else begin
            latches_in[index_ff] = wr_req.data[LATCH_BITS-1:0];
         end
      end
   end

   assign latches_next = latches_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         latches_ff <= '0;
      end else begin
         index_ff   <= index_in;
         latches_ff <= latches_in;
      end
   end

endmodule

/* hw/rtl/ilbm_bank_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank calculator
// Derives the program bank, graphics banks, slot layout and mirroring from
// the latch contents and the board variant.
// ----------------------------------------------------------------------------
module ilbm_bank_calc
   import ilbm_pkg::*;
(
   input  latch_array_type latches,
   input  variant_type     variant,
   output rsp_type         result
);

   logic [3:0][7:0]            chr;
   logic [LATCH_BITS-1:0]      sel;
   logic [2*LATCH_BITS-1:0]    base;
   logic [1:0]                 slot;
   logic [LATCH_BITS-1:0]      hi;

   always_comb begin
      hi = latches[HIGH_LATCH];
      for (int s = 0; s < 4; s++) begin
         slot = 2'(s);
         // In the 2K variants, simple mode takes every slot from latch 0.
         sel  = latches[MODE_LATCH][0] ? latches[0] : latches[{1'b0, slot}];
         base = {hi, sel};
         case (variant)
            VARIANT_2K_PAIR:  chr[slot] = {1'b0, base, slot[0]};
            VARIANT_2K_PLAIN: chr[slot] = {2'b00, base};
            VARIANT_2K_QUAD:  chr[slot] = {base, slot};
            VARIANT_1K_SPLIT: begin
               chr[slot] = {5'd0, latches[{1'b0, slot}]};
               case (slot)
                  2'd1:    chr[slot][4] = hi[0];
                  2'd2:    chr[slot][4] = hi[1];
                  2'd3:    begin
                     chr[slot][4] = hi[2];
                     chr[slot][3] = latches[EXT_LATCH][0];
                  end
                  default: ;
               endcase
            end
            default: chr[slot] = '0;
         endcase
      end
   end

   always_comb begin
      result.prg_bank        = latches[PRG_LATCH];
      result.chr_bank_0      = chr[0];
      result.chr_bank_1      = chr[1];
      result.chr_bank_2      = chr[2];
      result.chr_bank_3      = chr[3];
      result.chr_slot_layout = variant == VARIANT_1K_SPLIT;
      // Simple mode forces vertical mirroring.
      result.mirroring       = latches[MODE_LATCH][0] ? 2'd0
                                                      : latches[MODE_LATCH][2:1];
   end

endmodule

/* hw/rtl/ilbm_out_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output buffer
// Result register with a skid stage, so a new request is taken while a
// finished result still waits for the receiver.
// ----------------------------------------------------------------------------
module ilbm_out_buffer
   import ilbm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff,  main_data_in;
   rsp_type skid_data_ff,  skid_data_in;
   logic    push;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // Refill the result register from the skid stage first, then from input.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || out_ready) begin
         main_valid_in = skid_valid_ff || push;
         main_data_in  = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* hw/rtl/indexed_latch_bank_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed latch bank mapper
// Cartridge bank switch: CPU writes load an index register or a bank latch,
// and every write reports the resulting program and graphics banks.
// ----------------------------------------------------------------------------
// Usage:
//   Each CPU write enters as one request on req_ (address and data). A write
//   whose address under mask 0x4101 equals 0x4100 loads the index; any other
//   write stores the data in the latch that the index selects. Each request
//   yields exactly one response on rsp_ with the banks after that write.
//   The board variant is written on csr_ while no request is in flight; the
//   port is always ready.
//   The response is valid in the cycle after the request is accepted unless
//   the receiver stalls. Throughput is one request per cycle while it keeps
//   up, set by the single result register after the decode and bank logic.
//   When the receiver stalls, one further request is held in a skid stage;
//   req_tready then drops until the result register drains.
//   Reset clears the index, all latches, the variant and both output stages.
// ----------------------------------------------------------------------------
module indexed_latch_bank_mapper
   import ilbm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata: address[15:0], data[23:16]
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_BITS-1:0]       req_tdata,
   // rsp_tdata: prg_bank[2:0], chr_bank_0[10:3], chr_bank_1[18:11],
   //            chr_bank_2[26:19], chr_bank_3[34:27], chr_slot_layout[35],
   //            mirroring[37:36], zero fill above
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // board_variant
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_wdata
);

   variant_type     variant_ff;
   variant_type     variant_in;
   req_type         req;
   logic            req_fire;
   latch_array_type latches_next;
   rsp_type         result;
   rsp_type         rsp_data;

   assign req       = req_type'(req_tdata);
   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // Board variant register.
   assign variant_in = (csr_valid && csr_ready) ? variant_type'(csr_wdata) : variant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= VARIANT_2K_PAIR;
      end else begin
         variant_ff <= variant_in;
      end
   end

   ilbm_latch_file u_latch_file (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (req_fire),
      .wr_req       (req),
      .latches_next (latches_next)
   );

   ilbm_bank_calc u_bank_calc (
      .latches (latches_next),
      .variant (variant_ff),
      .result  (result)
   );

   ilbm_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {(RSP_TDATA_BITS - RSP_BITS)'(0), rsp_data};

endmodule

/* hw/rtl/ilbm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper port checker
// Port-level assertions for the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module ilbm_checker
   import ilbm_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A response only appears from an accepted request.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("response without request");

   // Backpressure only follows a stalled response that took a request.
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready && req_tvalid))
      else $error("request ready dropped without a stall");

   // In the 1K layout slot 0 only uses its latch bits.
   a_split_slot0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[10:6] == 5'd0)
      else $error("slot 0 bank out of range in 1K layout");

endmodule

bind indexed_latch_bank_mapper ilbm_checker u_ilbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/indexed_latch_bank_mapper_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed latch bank mapper testbench
// Drives CPU writes into the bank mapper across all board variants and checks
// every reported bank set against an in-bench model of the index register and
// the eight latches. Random stalls on both sides, including one long receiver
// hold-off, exercise the skid stage and input back-pressure.
// ----------------------------------------------------------------------------
module indexed_latch_bank_mapper_test;
   import ilbm_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int PRINT_LIMIT = 40;

   // Output codes that the model produces by name.
   localparam logic [1:0] MIRROR_VERTICAL = 2'd0;
   localparam logic       LAYOUT_2K       = 1'b0;
   localparam logic       LAYOUT_1K_SPLIT = 1'b1;

   // Model of the mapper state; one expected bank set per accepted write.
   class bank_tracker;
      logic [2:0]  index_reg;
      logic [7:0]  latch_bytes [NUM_LATCHES];
      variant_type variant;
      rsp_type     expected_banks [$];
      int          mismatches;

      function new();
         index_reg = '0;
         foreach (latch_bytes[i]) latch_bytes[i] = '0;
         variant = VARIANT_2K_PAIR;
         mismatches = 0;
      endfunction

      function void set_variant(logic [1:0] value);
         variant = variant_type'(value);
      endfunction

      function int pending();
         return expected_banks.size();
      endfunction

      // Graphics bank for one slot under the current variant.
      function logic [7:0] chr_bank(logic [1:0] slot);
         logic [2:0] low_bits;
         logic [7:0] bank;
         low_bits = latch_bytes[{1'b0, slot}][2:0];
         if (variant == VARIANT_1K_SPLIT) begin
            // Simple mode has no effect here; high bits come from latches 4 and 6.
            bank = {5'd0, low_bits};
            case (slot)
               2'd1: bank[4] = latch_bytes[HIGH_LATCH][0];
               2'd2: bank[4] = latch_bytes[HIGH_LATCH][1];
               2'd3: begin
                  bank[4] = latch_bytes[HIGH_LATCH][2];
                  bank[3] = latch_bytes[EXT_LATCH][0];
               end
               default: ;
            endcase
         end else begin
            // Simple mode makes every slot follow latch 0.
            if (latch_bytes[MODE_LATCH][0]) low_bits = latch_bytes[0][2:0];
            case (variant)
               VARIANT_2K_PAIR:
                  bank = {1'b0, latch_bytes[HIGH_LATCH][2:0], low_bits, slot[0]};
               VARIANT_2K_QUAD:
                  bank = {latch_bytes[HIGH_LATCH][2:0], low_bits, slot};
               default:
                  bank = {2'b00, latch_bytes[HIGH_LATCH][2:0], low_bits};
            endcase
         end
         return bank;
      endfunction

      // Applies one CPU write and queues the banks that follow from it.
      function void note_write(logic [15:0] addr, logic [7:0] data);
         rsp_type banks;
         if ((addr & SEL_MASK) == SEL_MATCH) index_reg = data[2:0];
         else latch_bytes[index_reg] = data;
         banks.prg_bank        = latch_bytes[PRG_LATCH][2:0];
         banks.chr_bank_0      = chr_bank(2'd0);
         banks.chr_bank_1      = chr_bank(2'd1);
         banks.chr_bank_2      = chr_bank(2'd2);
         banks.chr_bank_3      = chr_bank(2'd3);
         banks.chr_slot_layout = (variant == VARIANT_1K_SPLIT) ? LAYOUT_1K_SPLIT : LAYOUT_2K;
         banks.mirroring       = latch_bytes[MODE_LATCH][0] ? MIRROR_VERTICAL
                                                            : latch_bytes[MODE_LATCH][2:1];
         expected_banks.push_back(banks);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_LIMIT) $display("%0t ns: bank mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
      endtask

      // Compares one reported bank set with the oldest expectation.
      task check_banks(logic [RSP_TDATA_BITS-1:0] word);
         rsp_type got;
         rsp_type want;
         if (expected_banks.size() == 0) begin
            report_mismatch("response with no write outstanding");
            return;
         end
         got  = rsp_type'(word[RSP_BITS-1:0]);
         want = expected_banks.pop_front();
         check_field("prg_bank", 8'(got.prg_bank), 8'(want.prg_bank));
         check_field("chr_bank_0", got.chr_bank_0, want.chr_bank_0);
         check_field("chr_bank_1", got.chr_bank_1, want.chr_bank_1);
         check_field("chr_bank_2", got.chr_bank_2, want.chr_bank_2);
         check_field("chr_bank_3", got.chr_bank_3, want.chr_bank_3);
         check_field("chr_slot_layout", 8'(got.chr_slot_layout), 8'(want.chr_slot_layout));
         check_field("mirroring", 8'(got.mirroring), 8'(want.mirroring));
         check_field("zero fill", 8'(word[RSP_TDATA_BITS-1:RSP_BITS]), 8'd0);
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [1:0]                csr_wdata = '0;

   bank_tracker banks_model = new();

   logic idle_on = 1'b0;
   int   hold_ask = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   stall_left = 0;
   int   run_left = 0;
   int   cycle_count = 0;

   indexed_latch_bank_mapper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watch all three handshakes and keep the model in step with the block.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) banks_model.set_variant(csr_wdata);
         if (req_tvalid && req_tready)
            banks_model.note_write(req_tdata[15:0], req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready) banks_model.check_banks(rsp_tdata);
      end
   end

   // Receiver: a long hold-off on request, otherwise random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_ask != hold_seen) begin
         hold_seen  <= hold_ask;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (run_left != 0) begin
         run_left   <= run_left - 1;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left <= $urandom_range(1, 9) - 1;
         rsp_tready <= 1'b0;
      end else begin
         run_left   <= $urandom_range(1, 24) - 1;
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("indexed_latch_bank_mapper_test NOT OK");
         $finish;
      end
   end

   // Offers one CPU write, after an optional idle burst, and waits for it to go in.
   task automatic send_write(logic [15:0] addr, logic [7:0] data);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tdata  <= {data, addr};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   function automatic logic [15:0] index_address();
      return (16'($urandom) & ~SEL_MASK) | SEL_MATCH;
   endfunction

   // Any address that misses the index decode on at least one mask bit.
   function automatic logic [15:0] latch_address();
      logic [15:0] addr;
      addr = 16'($urandom);
      if ((addr & SEL_MASK) == SEL_MATCH) begin
         case ($urandom_range(0, 2))
            0: addr[0] = 1'b1;
            1: addr[8] = 1'b0;
            default: addr[14] = 1'b0;
         endcase
      end
      return addr;
   endfunction

   // Stops offering writes and waits until every bank set has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (banks_model.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_variant(variant_type value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   // Mostly index-then-latch pairs with random content, plus loose writes.
   task automatic run_random(int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_write(index_address(), 8'($urandom));
            send_write(latch_address(), 8'($urandom));
            sent += 2;
         end else if (pick < 9) begin
            send_write(latch_address(), 8'($urandom));
            sent++;
         end else begin
            send_write(16'($urandom), 8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      variant_type phase_variant;
      repeat (3) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;
      program_variant(VARIANT_2K_PAIR);

      // Field extremes, decode corners and every mirroring mode.
      send_write(16'h0000, 8'h00);
      send_write(16'hFFFF, 8'hFF);
      send_write(16'h4100, 8'hFD);   // index keeps only the low bits
      send_write(16'h4101, 8'hFF);   // one bit off the decode: latch write
      send_write(16'hFFFE, 8'h04);   // decode ignores the unmasked bits
      send_write(16'h4000, 8'hFF);
      send_write(16'h7F00, 8'h01);
      send_write(16'h0100, 8'h03);
      send_write(16'h4100, 8'h02);
      send_write(16'h8000, 8'h06);
      send_write(16'h4100, 8'h03);
      send_write(16'h6001, 8'h05);
      send_write(16'hC100, 8'h07);
      send_write(16'h6000, 8'h02);
      send_write(16'h6000, 8'h04);
      send_write(16'h6000, 8'h06);
      send_write(16'h6000, 8'h07);   // simple mode forces vertical mirroring
      send_write(16'h4100, 8'h06);
      send_write(16'h6000, 8'h01);
      drain();

      // Simple mode must leave the 1K graphics banks alone.
      program_variant(VARIANT_1K_SPLIT);
      send_write(16'h4100, 8'h07);
      send_write(16'h6000, 8'h01);
      send_write(16'h6000, 8'h00);
      send_write(16'h4100, 8'h00);
      send_write(16'h6000, 8'hFF);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         phase_variant = (phase < 4) ? variant_type'(phase) : variant_type'($urandom_range(0, 3));
         program_variant(phase_variant);
         if (phase == 1) hold_ask <= hold_ask + 1;
         if (phase == 5) idle_on <= 1'b0;
         run_random(200);
      end
      drain();
      repeat (4) @(posedge clock);

      if (banks_model.mismatches == 0) begin
         $display("indexed_latch_bank_mapper_test OK");
      end else begin
         $display("indexed_latch_bank_mapper_test NOT OK");
      end
      $finish;
   end

endmodule
